[hw/rtl/block_cache_tag_controller_assert.svh]
// ----------------------------------------------------------------------------
// Block cache tag controller assertion macros
// Implication and next-cycle implication checks, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BLOCK_CACHE_TAG_CONTROLLER_ASSERT_SVH
`define BLOCK_CACHE_TAG_CONTROLLER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define BCTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define BCTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BCTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BCTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[hw/rtl/bctc_pkg.sv]
// ----------------------------------------------------------------------------
// Block cache tag controller package
// Field widths, request kinds and action codes shared by the design files.
// ----------------------------------------------------------------------------
package bctc_pkg;

    // Default number of cache slots.
    localparam int NUM_SLOTS_DEF = 32;

    // Field widths.
    localparam int REQ_TYPE_W = 2;
    localparam int BLOCK_W    = 32;
    localparam int ACTION_W   = 3;
    localparam int SLOT_OUT_W = 5;
    localparam int COUNT_W    = 32;

    // Request kinds.
    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_SYNC  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_kind;

    // Commands issued toward the slot store and the disk.
    typedef enum logic [ACTION_W-1:0] {
        ACT_SERVE     = 3'd0,
        ACT_FILL      = 3'd1,
        ACT_WRITEBACK = 3'd2,
        ACT_STORE     = 3'd3,
        ACT_SYNC_DONE = 3'd4
    } t_action;

    // One result item as held in the output register.
    typedef struct packed {
        t_action               action;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [BLOCK_W-1:0]    disk_block;
        logic                  last;
        logic [COUNT_W-1:0]    hit_count;
        logic [COUNT_W-1:0]    miss_count;
    } t_rsp;

endpackage

[hw/rtl/bctc_if.sv]
// ----------------------------------------------------------------------------
// Block cache tag controller channels
// Valid/ready request and result channels with their payload fields.
// ----------------------------------------------------------------------------
interface bctc_req_if import bctc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [BLOCK_W-1:0]    block_number;

    modport source (output valid, req_type, block_number, input ready);
    modport sink (input valid, req_type, block_number, output ready);
endinterface

interface bctc_rsp_if import bctc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [BLOCK_W-1:0]    disk_block;
    logic                  last;
    logic [COUNT_W-1:0]    hit_count;
    logic [COUNT_W-1:0]    miss_count;

    modport source (output valid, action, slot_index, disk_block, last, hit_count,
                    miss_count, input ready);
    modport sink (input valid, action, slot_index, disk_block, last, hit_count,
                  miss_count, output ready);
endinterface

[hw/rtl/block_cache_tag_controller.sv]
// ----------------------------------------------------------------------------
// Block cache tag controller
// Tag lookup and write-back policy for a fully associative block cache with
// round-robin replacement. Emits slot and disk commands for read, write and sync.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake     Payload
//  i_req     in   valid/ready   req_type, block_number
//  o_rsp     out  valid/ready   action, slot_index, disk_block, last,
//                               hit_count, miss_count
//
// A lookup walks the tag RAM one slot per cycle through a single tag
// comparator to decide hit or miss, then emits its commands one after another
// (up to three commands for a dirty read miss).
// A sync visits every slot once, writes back each dirty slot and then
// emits the done command.
// Reset clears valid and dirty bits, the hand and both counters at once.
// A stalled result channel holds the emitting states; a new request is taken
// as soon as the final command of the previous one sits in the output register.
// ----------------------------------------------------------------------------
`include "block_cache_tag_controller_assert.svh"

module block_cache_tag_controller import bctc_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bctc_req_if.sink   i_req,
    bctc_rsp_if.source o_rsp
);

    localparam int             IW        = $clog2(NUM_SLOTS);
    localparam logic [IW-1:0]  LAST_SLOT = IW'(NUM_SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_VICTIM,
        S_WB,
        S_FILL,
        S_SERVE,
        S_STORE,
        S_SYNC,
        S_SWB,
        S_DONE
    } t_state;

    t_state              r_state;
    t_req_kind           r_kind;
    logic [BLOCK_W-1:0]  r_block;
    logic [IW-1:0]       r_idx;
    logic [IW-1:0]       r_cmp_idx;
    logic                r_cmp_vld;
    logic [IW-1:0]       r_slot;
    logic [IW-1:0]       r_hand;
    logic [NUM_SLOTS-1:0] r_valid;
    logic [NUM_SLOTS-1:0] r_dirty;
    logic [COUNT_W-1:0]  r_hits;
    logic [COUNT_W-1:0]  r_misses;
    logic                r_out_vld;
    t_rsp                r_out;

    logic                req_fire;
    logic                out_free;
    logic                out_load;
    logic                hit_now;
    logic [IW-1:0]       rd_addr;
    logic                tag_we;
    logic [BLOCK_W-1:0]  rd_tag;

    // Next slot in round-robin order.
    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
        logic [IW-1:0] nxt;
        nxt = (idx == LAST_SLOT) ? '0 : idx + IW'(1);
        return nxt;
    endfunction

    // Slot number as carried on the result channel (low bits only).
    function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [IW-1:0] idx);
        logic [SLOT_OUT_W+IW-1:0] ext;
        ext = {{SLOT_OUT_W{1'b0}}, idx};
        return ext[SLOT_OUT_W-1:0];
    endfunction

    // Handshake qualifiers.
    assign req_fire = i_req.valid && i_req.ready;
    assign out_free = !r_out_vld || o_rsp.ready;

    // The output register takes a new command in every emitting state once it is free.
    assign out_load = out_free &&
                      (r_state inside {S_WB, S_FILL, S_SERVE, S_STORE, S_SWB, S_DONE});

    // Shared tag comparator on the registered RAM read data.
    assign hit_now = r_cmp_vld && r_valid[r_cmp_idx] && (rd_tag == r_block);

    // Tag RAM port control.
    always_comb begin
        case (r_state)
            S_SCAN, S_SYNC, S_SWB: rd_addr = r_idx;
            default:               rd_addr = r_slot;
        endcase
        tag_we = ((r_state == S_FILL) || (r_state == S_STORE)) && out_free;
    end

    bctc_tag_ram #(
        .DEPTH (NUM_SLOTS),
        .AW    (IW)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tag_we),
        .i_wr_addr (r_slot),
        .i_wr_data (r_block),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_tag)
    );

    // Sequencer, slot status and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
            r_hand    <= '0;
            r_valid   <= '0;
            r_dirty   <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        r_kind    <= t_req_kind'(i_req.req_type);
                        r_block   <= i_req.block_number;
                        r_idx     <= '0;
                        r_cmp_vld <= 1'b0;
                        case (t_req_kind'(i_req.req_type))
                            REQ_READ, REQ_WRITE: r_state <= S_SCAN;
                            REQ_SYNC:            r_state <= S_SYNC;
                            default:             r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_idx     <= next_slot(r_idx);
                    r_cmp_idx <= r_idx;
                    r_cmp_vld <= 1'b1;
                    if (hit_now) begin
                        r_slot <= r_cmp_idx;
                        if (r_kind == REQ_READ) begin
                            r_hits  <= r_hits + COUNT_W'(1);
                            r_state <= S_SERVE;
                        end else begin
                            r_state <= S_STORE;
                        end
                    end else if (r_cmp_vld && (r_cmp_idx == LAST_SLOT)) begin
                        r_slot <= r_hand;
                        r_hand <= next_slot(r_hand);
                        if (r_kind == REQ_READ) begin
                            r_misses <= r_misses + COUNT_W'(1);
                        end
                        r_state <= S_VICTIM;
                    end
                end
                S_VICTIM: begin
                    if (r_valid[r_slot] && r_dirty[r_slot]) begin
                        r_state <= S_WB;
                    end else if (r_kind == REQ_READ) begin
                        r_state <= S_FILL;
                    end else begin
                        r_state <= S_STORE;
                    end
                end
                S_WB: begin
                    if (out_free) begin
                        r_out     <= '{ACT_WRITEBACK, slot_out(r_slot), rd_tag, 1'b0,
                                       r_hits, r_misses};
                        r_state   <= (r_kind == REQ_READ) ? S_FILL : S_STORE;
                    end
                end
                S_FILL: begin
                    if (out_free) begin
                        r_out            <= '{ACT_FILL, slot_out(r_slot), r_block, 1'b0,
                                              r_hits, r_misses};
                        r_valid[r_slot]  <= 1'b1;
                        r_dirty[r_slot]  <= 1'b0;
                        r_state          <= S_SERVE;
                    end
                end
                S_SERVE: begin
                    if (out_free) begin
                        r_out     <= '{ACT_SERVE, slot_out(r_slot), r_block, 1'b1,
                                       r_hits, r_misses};
                        r_state   <= S_IDLE;
                    end
                end
                S_STORE: begin
                    if (out_free) begin
                        r_out           <= '{ACT_STORE, slot_out(r_slot), r_block, 1'b1,
                                             r_hits, r_misses};
                        r_valid[r_slot] <= 1'b1;
                        r_dirty[r_slot] <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                S_SYNC: begin
                    if (r_valid[r_idx] && r_dirty[r_idx]) begin
                        r_state <= S_SWB;
                    end else if (r_idx == LAST_SLOT) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= next_slot(r_idx);
                    end
                end
                S_SWB: begin
                    if (out_free) begin
                        r_out          <= '{ACT_WRITEBACK, slot_out(r_idx), rd_tag, 1'b0,
                                            r_hits, r_misses};
                        r_dirty[r_idx] <= 1'b0;
                        if (r_idx == LAST_SLOT) begin
                            r_state <= S_DONE;
                        end else begin
                            r_idx   <= next_slot(r_idx);
                            r_state <= S_SYNC;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out     <= '{ACT_SYNC_DONE, '0, '0, 1'b1, r_hits, r_misses};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Channel outputs.
    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.action     = r_out.action;
    assign o_rsp.slot_index = r_out.slot_index;
    assign o_rsp.disk_block = r_out.disk_block;
    assign o_rsp.last       = r_out.last;
    assign o_rsp.hit_count  = r_out.hit_count;
    assign o_rsp.miss_count = r_out.miss_count;

    // A slot is never dirty unless it holds a valid tag.
    `BCTC_ASSERT_IMP(a_dirty_needs_valid, i_clk, i_rst_n, 1'b1, (r_dirty & ~r_valid) == '0, "dirty slot without valid tag")
    // An accepted sync starts the slot walk in the next cycle.
    `BCTC_ASSERT_NXT(a_sync_walk, i_clk, i_rst_n, req_fire && (i_req.req_type == REQ_SYNC), r_state == S_SYNC, "sync request did not start the walk")
    // The hit counter only ever steps by one.
    `BCTC_ASSERT_IMP(a_hit_step, i_clk, i_rst_n, r_hits != $past(r_hits), r_hits == $past(r_hits) + COUNT_W'(1), "hit counter jumped")
    // Closing commands of a request always carry the last flag.
    `BCTC_ASSERT_IMP(a_last_flag, i_clk, i_rst_n, r_out_vld && ((r_out.action == ACT_SERVE) || (r_out.action == ACT_STORE) || (r_out.action == ACT_SYNC_DONE)), r_out.last, "closing command without last flag")

endmodule

[hw/rtl/bctc_tag_ram.sv]
// ----------------------------------------------------------------------------
// Block cache tag RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bctc_tag_ram import bctc_pkg::*; #(
    parameter int DEPTH = NUM_SLOTS_DEF,
    parameter int AW    = $clog2(NUM_SLOTS_DEF)
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [BLOCK_W-1:0] i_wr_data,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [BLOCK_W-1:0] o_rd_data
);

    logic [BLOCK_W-1:0] r_mem [DEPTH];
    logic [BLOCK_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
